@@ design/gsh_pkg.sv @@
// Shared types and constants for the Graham scan convex hull block.
`default_nettype none
package gsh_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int COORD_BITS_DEF = 16;

   // Orientation of an ordered point triple (y grows upward)
   typedef enum logic [1:0] {
      ORI_COL = 2'd0,
      ORI_CW  = 2'd1,
      ORI_CCW = 2'd2
   } orient_type;

   // Result of the geometry unit, valid in the cycle after its operands
   typedef struct packed {
      orient_type ori;
      logic       q_closer;
      logic       q_is_p;
      logic       r_is_p;
   } geom_res_type;

   typedef enum logic [4:0] {
      ST_LOAD, ST_PV_RD, ST_PV_CMP, ST_PV_SW1, ST_PV_SW2,
      ST_SO_RDT, ST_SO_TMP, ST_SO_RDC, ST_SO_LD, ST_SO_DEC, ST_SO_WT,
      ST_DD_INIT, ST_DD_LD0, ST_DD_NEXT, ST_DD_LD1, ST_DD_DEC,
      ST_SC_INIT, ST_SC_RD, ST_SC_LD, ST_SC_MAIN, ST_SC_LDP, ST_SC_DEC,
      ST_SC_POP, ST_SC_POPLD, ST_OUT_RD, ST_OUT_LD, ST_EMPTY
   } state_type;

endpackage
`default_nettype wire

@@ design/gsh_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gsh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

@@ design/gsh_geom.sv @@
// Geometry unit: orientation of p,q,r and distance compare of q and r about p.
`default_nettype none
module gsh_geom #(
   parameter int COORD_BITS = gsh_pkg::COORD_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic [2*COORD_BITS-1:0] p,
   input  wire logic [2*COORD_BITS-1:0] q,
   input  wire logic [2*COORD_BITS-1:0] r,
   output gsh_pkg::geom_res_type        res
);
   import gsh_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int DW = CB + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] ax, ay, bx, by;
   logic signed [PW-1:0] lhs_ff, rhs_ff, qx2_ff, qy2_ff, rx2_ff, ry2_ff;
   logic                 qz_ff, rz_ff;
   logic [PW:0]          dq, dr;

   // coordinate differences, sign extended
   assign ax = DW'($signed(q[CB-1:0])) - DW'($signed(p[CB-1:0]));
   assign ay = DW'($signed(q[2*CB-1:CB])) - DW'($signed(p[2*CB-1:CB]));
   assign bx = DW'($signed(r[CB-1:0])) - DW'($signed(p[CB-1:0]));
   assign by = DW'($signed(r[2*CB-1:CB])) - DW'($signed(p[2*CB-1:CB]));

   // register the products
   always_ff @(posedge clock) begin
      lhs_ff <= ay * bx;
      rhs_ff <= ax * by;
      qx2_ff <= ax * ax;
      qy2_ff <= ay * ay;
      rx2_ff <= bx * bx;
      ry2_ff <= by * by;
      qz_ff  <= (q == p);
      rz_ff  <= (r == p);
   end

   // compare stage
   assign dq = {1'b0, qx2_ff} + {1'b0, qy2_ff};
   assign dr = {1'b0, rx2_ff} + {1'b0, ry2_ff};

   always_comb begin
      if (lhs_ff == rhs_ff) begin
         res.ori = ORI_COL;
      end else if (lhs_ff > rhs_ff) begin
         res.ori = ORI_CW;
      end else begin
         res.ori = ORI_CCW;
      end
      res.q_closer = (dq < dr);
      res.q_is_p   = qz_ff;
      res.r_is_p   = rz_ff;
   end

endmodule
`default_nettype wire

@@ design/graham_scan_convex_hull_top.sv @@
// Graham scan convex hull: point store, sort, collinear filter, scan, emit.
// Points are taken one per cycle while loading; the item with tlast starts the hull build.
// Phases in order: pivot search, insertion sort (O(n^2) compares), collinear filter, scan
// (a push or pop per step), then one output per hull vertex.
// The point memory's single read port paces the pivot, sort, filter and scan phases.
// Synchronous active-high reset clears the sequencer, point count and output valid.
`default_nettype none
module graham_scan_convex_hull_top #(
   parameter int MAX_POINTS = gsh_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = gsh_pkg::COORD_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // point_x, point_y, zero pad
   input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  wire logic req_tlast,    // last_point
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // hull_x, hull_y, zero pad
   output logic [((2*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic      rsp_tuser,    // hull_empty
   output logic      rsp_tlast     // last_vertex
);
   import gsh_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int PTW = 2 * CB;
   localparam int TDW = ((2 * CB + 7) / 8) * 8;
   localparam int AW  = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam logic [CW-1:0] ONE   = CW'(1);
   localparam logic [CW-1:0] TWO   = CW'(2);
   localparam logic [CW-1:0] THREE = CW'(3);
   localparam logic [CW-1:0] FULL  = CW'(MAX_POINTS);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic [CW-1:0] k_ff, k_in, m_ff, m_in, d_ff, d_in;
   logic [CW-1:0] bidx_ff, bidx_in;
   logic [PTW-1:0] best_ff, best_in, p0_ff, p0_in, pivot_ff, pivot_in;
   logic [PTW-1:0] t_ff, t_in, cpt_ff, cpt_in, cur_ff, cur_in, nxt_ff, nxt_in;
   logic [PTW-1:0] t1_ff, t1_in, t2_ff, t2_in;
   logic           rv_ff, rv_in, rlast_ff, rlast_in, remp_ff, remp_in;
   logic [PTW-1:0] rpt_ff, rpt_in;

   logic           pt_we, stk_we;
   logic [AW-1:0]  pt_waddr, pt_raddr, stk_waddr, stk_raddr;
   logic [PTW-1:0] pt_wdata, pt_rdata, stk_wdata, stk_rdata;
   logic [PTW-1:0] g_p, g_q, g_r;
   geom_res_type   g_res;

   logic [CW-1:0]  jm1, kp1, ip1, dm2;
   logic           out_free, in_acc, before_q, best_less;
   logic [PTW-1:0] in_pt;

   assign jm1 = j_ff - ONE;
   assign kp1 = k_ff + ONE;
   assign ip1 = i_ff + ONE;
   assign dm2 = d_ff - TWO;
   assign out_free = !rv_ff || rsp_tready;
   assign in_acc   = req_tvalid && req_tready;
   assign in_pt    = req_tdata[PTW-1:0];

   gsh_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_pt_ram (
      .clock(clock), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
      .raddr(pt_raddr), .rdata(pt_rdata)
   );

   gsh_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_stk_ram (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(stk_raddr), .rdata(stk_rdata)
   );

   gsh_geom #(.COORD_BITS(CB)) u_geom (
      .clock(clock), .p(g_p), .q(g_q), .r(g_r), .res(g_res)
   );

   // polar order: q sorts before r about the pivot
   always_comb begin
      if (g_res.q_is_p) begin
         before_q = !g_res.r_is_p;
      end else if (g_res.r_is_p) begin
         before_q = 1'b0;
      end else if (g_res.ori == ORI_CCW) begin
         before_q = 1'b1;
      end else if (g_res.ori == ORI_CW) begin
         before_q = 1'b0;
      end else begin
         before_q = g_res.q_closer;
      end
   end

   // lowest y, then lowest x
   assign best_less = ($signed(pt_rdata[PTW-1:CB]) < $signed(best_ff[PTW-1:CB])) ||
                      ((pt_rdata[PTW-1:CB] == best_ff[PTW-1:CB]) &&
                       ($signed(pt_rdata[CB-1:0]) < $signed(best_ff[CB-1:0])));

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      n_ff <= n_in;  i_ff <= i_in;  j_ff <= j_in;  k_ff <= k_in;
      m_ff <= m_in;  d_ff <= d_in;  bidx_ff <= bidx_in;
      best_ff <= best_in;  p0_ff <= p0_in;  pivot_ff <= pivot_in;
      t_ff <= t_in;  cpt_ff <= cpt_in;  cur_ff <= cur_in;  nxt_ff <= nxt_in;
      t1_ff <= t1_in;  t2_ff <= t2_in;
      rlast_ff <= rlast_in;  remp_ff <= remp_in;  rpt_ff <= rpt_in;
   end

   // sequencer: next state, memory ports, geometry operands
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;  n_in = n_ff;  i_in = i_ff;  j_in = j_ff;
      k_in = k_ff;  m_in = m_ff;  d_in = d_ff;  bidx_in = bidx_ff;
      best_in = best_ff;  p0_in = p0_ff;  pivot_in = pivot_ff;
      t_in = t_ff;  cpt_in = cpt_ff;  cur_in = cur_ff;  nxt_in = nxt_ff;
      t1_in = t1_ff;  t2_in = t2_ff;
      rv_in = rv_ff && !rsp_tready;
      rlast_in = rlast_ff;  remp_in = remp_ff;  rpt_in = rpt_ff;
      req_tready = 1'b0;
      pt_we = 1'b0;  pt_waddr = i_ff[AW-1:0];  pt_wdata = cur_ff;
      pt_raddr = i_ff[AW-1:0];
      stk_we = 1'b0;  stk_waddr = d_ff[AW-1:0];  stk_wdata = cur_ff;
      stk_raddr = k_ff[AW-1:0];
      g_p = pivot_ff;  g_q = t_ff;  g_r = pt_rdata;

      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            pt_waddr = count_ff[AW-1:0];
            pt_wdata = in_pt;
            if (in_acc) begin
               pt_we = (count_ff != FULL);
               if (req_tlast) begin
                  n_in     = (count_ff != FULL) ? count_ff + ONE : count_ff;
                  count_in = '0;
                  i_in     = '0;
                  state_in = ST_PV_RD;
               end else if (count_ff != FULL) begin
                  count_in = count_ff + ONE;
               end
            end
         end
         ST_PV_RD: begin
            state_in = ST_PV_CMP;
         end
         ST_PV_CMP: begin
            if (i_ff == '0) begin
               p0_in   = pt_rdata;
               best_in = pt_rdata;
               bidx_in = '0;
            end else if (best_less) begin
               best_in = pt_rdata;
               bidx_in = i_ff;
            end
            i_in = ip1;
            state_in = (ip1 == n_ff) ? ST_PV_SW1 : ST_PV_RD;
         end
         ST_PV_SW1: begin
            pt_we = 1'b1;  pt_waddr = bidx_ff[AW-1:0];  pt_wdata = p0_ff;
            state_in = ST_PV_SW2;
         end
         ST_PV_SW2: begin
            pt_we = 1'b1;  pt_waddr = '0;  pt_wdata = best_ff;
            pivot_in = best_ff;
            i_in = TWO;
            state_in = (n_ff < THREE) ? ST_DD_INIT : ST_SO_RDT;
         end
         ST_SO_RDT: begin
            state_in = ST_SO_TMP;
         end
         ST_SO_TMP: begin
            t_in = pt_rdata;
            j_in = i_ff;
            state_in = ST_SO_RDC;
         end
         ST_SO_RDC: begin
            pt_raddr = jm1[AW-1:0];
            state_in = ST_SO_LD;
         end
         ST_SO_LD: begin
            cpt_in = pt_rdata;
            state_in = ST_SO_DEC;
         end
         ST_SO_DEC: begin
            // shift the neighbor up while the held point sorts first
            if (before_q) begin
               pt_we = 1'b1;  pt_waddr = j_ff[AW-1:0];  pt_wdata = cpt_ff;
               j_in = jm1;
               state_in = (j_ff > THREE - ONE) && (jm1 > ONE) ? ST_SO_RDC : ST_SO_WT;
            end else begin
               state_in = ST_SO_WT;
            end
         end
         ST_SO_WT: begin
            pt_we = 1'b1;  pt_waddr = j_ff[AW-1:0];  pt_wdata = t_ff;
            i_in = ip1;
            state_in = (ip1 == n_ff) ? ST_DD_INIT : ST_SO_RDT;
         end
         ST_DD_INIT: begin
            m_in = ONE;  k_in = ONE;
            pt_raddr = ONE[AW-1:0];
            state_in = (n_ff <= ONE) ? ST_EMPTY : ST_DD_LD0;
         end
         ST_DD_LD0: begin
            cur_in = pt_rdata;
            state_in = ST_DD_NEXT;
         end
         ST_DD_NEXT: begin
            pt_raddr = kp1[AW-1:0];
            if (kp1 == n_ff) begin
               pt_we = 1'b1;  pt_waddr = m_ff[AW-1:0];  pt_wdata = cur_ff;
               m_in = m_ff + ONE;
               state_in = ST_SC_INIT;
            end else begin
               state_in = ST_DD_LD1;
            end
         end
         ST_DD_LD1: begin
            g_q = cur_ff;
            nxt_in = pt_rdata;
            state_in = ST_DD_DEC;
         end
         ST_DD_DEC: begin
            // keep only the farthest point of a collinear run
            if (g_res.ori != ORI_COL) begin
               pt_we = 1'b1;  pt_waddr = m_ff[AW-1:0];  pt_wdata = cur_ff;
               m_in = m_ff + ONE;
            end
            cur_in = nxt_ff;
            k_in = kp1;
            state_in = ST_DD_NEXT;
         end
         ST_SC_INIT: begin
            i_in = '0;
            state_in = (m_ff < THREE) ? ST_EMPTY : ST_SC_RD;
         end
         ST_SC_RD: begin
            state_in = ST_SC_LD;
         end
         ST_SC_LD: begin
            stk_we = 1'b1;  stk_waddr = i_ff[AW-1:0];  stk_wdata = pt_rdata;
            t2_in = t1_ff;
            t1_in = pt_rdata;
            i_in = ip1;
            if (i_ff == TWO) begin
               d_in = THREE;
               state_in = ST_SC_MAIN;
            end else begin
               state_in = ST_SC_RD;
            end
         end
         ST_SC_MAIN: begin
            k_in = '0;
            state_in = (i_ff == m_ff) ? ST_OUT_RD : ST_SC_LDP;
         end
         ST_SC_LDP: begin
            g_p = t2_ff;  g_q = t1_ff;
            cur_in = pt_rdata;
            state_in = ST_SC_DEC;
         end
         ST_SC_DEC: begin
            // pop on a non-left turn, else push
            if ((d_ff > TWO) && (g_res.ori != ORI_CCW)) begin
               d_in = d_ff - ONE;
               t1_in = t2_ff;
               state_in = ST_SC_POP;
            end else begin
               stk_we = 1'b1;  stk_waddr = d_ff[AW-1:0];  stk_wdata = cur_ff;
               t2_in = t1_ff;
               t1_in = cur_ff;
               d_in = d_ff + ONE;
               i_in = ip1;
               state_in = ST_SC_MAIN;
            end
         end
         ST_SC_POP: begin
            stk_raddr = dm2[AW-1:0];
            state_in = ST_SC_POPLD;
         end
         ST_SC_POPLD: begin
            g_p = stk_rdata;  g_q = t1_ff;  g_r = cur_ff;
            t2_in = stk_rdata;
            state_in = ST_SC_DEC;
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            if (out_free) begin
               rv_in = 1'b1;
               rpt_in = stk_rdata;
               remp_in = 1'b0;
               rlast_in = (kp1 == d_ff);
               k_in = kp1;
               state_in = (kp1 == d_ff) ? ST_LOAD : ST_OUT_RD;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rv_in = 1'b1;
               rpt_in = '0;
               remp_in = 1'b1;
               rlast_in = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = TDW'(rpt_ff);
   assign rsp_tuser  = remp_ff;
   assign rsp_tlast  = rlast_ff;

   // filtered run never outgrows the points read so far
   a_dd_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DD_DEC) |-> (m_ff <= k_ff))
      else $error("filter write index passed read index");

   // stack stays within the filtered set
   a_sc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SC_DEC) |-> (d_ff >= TWO) && (d_ff <= i_ff) && (i_ff < m_ff))
      else $error("scan stack depth out of range");

   // insertion index stays in the sorted window
   a_so_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SO_DEC) |-> (j_ff >= TWO) && (j_ff <= i_ff))
      else $error("sort index out of range");

   // a result load never overwrites a result that was not taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_tready) |=> rv_ff && $stable(rpt_ff))
      else $error("result overwritten before transaction");

endmodule
`default_nettype wire

@@ test/graham_scan_convex_hull_top_tb.sv @@
// Testbench for the Graham scan convex hull block: directed and random point sets.
`default_nettype none
module graham_scan_convex_hull_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gsh_pkg::*;

   localparam int CB    = COORD_BITS_DEF;
   localparam int MAXP  = MAX_POINTS_DEF;
   localparam int DW    = ((2*CB+7)/8)*8;

   typedef struct {
      logic [CB-1:0] x;
      logic [CB-1:0] y;
      logic          empty;
      logic          last;
   } vertex_type;

   typedef struct {
      int   x;
      int   y;
      bit   last;
      bit   typed;   // expectation typed in below: empty hull
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [DW-1:0] req_tdata = '0;  // point_x, point_y, zero pad
   logic          req_tlast = 1'b0; // last_point
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [DW-1:0] rsp_tdata;       // hull_x, hull_y, zero pad
   logic          rsp_tuser;       // hull_empty
   logic          rsp_tlast;       // last_vertex

   graham_scan_convex_hull_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   longint     set_x[MAXP];
   longint     set_y[MAXP];
   int         set_count = 0;
   longint     piv_x, piv_y;
   vertex_type hull_q[$];
   int         send_idle = 28;
   int         recv_idle = 76;
   int         mismatches = 0;

   function automatic orient_type turn(longint px, longint py, longint qx, longint qy,
                                       longint rx, longint ry);
      longint lhs;
      longint rhs;
      lhs = (qy - py) * (rx - px);
      rhs = (qx - px) * (ry - py);
      if (lhs == rhs) return ORI_COL;
      return (lhs > rhs) ? ORI_CW : ORI_CCW;
   endfunction

   function automatic longint dist_sq(longint ax, longint ay);
      return (ax - piv_x) * (ax - piv_x) + (ay - piv_y) * (ay - piv_y);
   endfunction

   // Sort order about the pivot: pivot copies first, then angle, then distance
   function automatic bit sorts_ahead(longint ax, longint ay, longint bx, longint by);
      bit         a_piv;
      bit         b_piv;
      orient_type o;
      a_piv = (ax == piv_x && ay == piv_y);
      b_piv = (bx == piv_x && by == piv_y);
      if (a_piv) return !b_piv;
      if (b_piv) return 1'b0;
      o = turn(piv_x, piv_y, ax, ay, bx, by);
      if (o == ORI_CCW) return 1'b1;
      if (o == ORI_CW) return 1'b0;
      return dist_sq(ax, ay) < dist_sq(bx, by);
   endfunction

   // Build the hull of the held set and queue its vertices
   function automatic void predict_hull(bit keep);
      int         n;
      int         best;
      int         j;
      int         m;
      int         depth;
      int         stk[MAXP];
      longint     tx, ty;
      vertex_type v;
      n = set_count;
      set_count = 0;
      best = 0;
      for (int i = 1; i < n; i++)
         if (set_y[i] < set_y[best] || (set_y[i] == set_y[best] && set_x[i] < set_x[best]))
            best = i;
      tx = set_x[0]; ty = set_y[0];
      set_x[0] = set_x[best]; set_y[0] = set_y[best];
      set_x[best] = tx; set_y[best] = ty;
      piv_x = set_x[0]; piv_y = set_y[0];
      for (int i = 2; i < n; i++) begin
         tx = set_x[i]; ty = set_y[i];
         j = i;
         while (j > 1 && sorts_ahead(tx, ty, set_x[j-1], set_y[j-1])) begin
            set_x[j] = set_x[j-1]; set_y[j] = set_y[j-1];
            j--;
         end
         set_x[j] = tx; set_y[j] = ty;
      end
      // keep the farthest point of each collinear run
      m = 1;
      for (int i = 1; i < n; i++) begin
         while (i + 1 < n &&
                turn(piv_x, piv_y, set_x[i], set_y[i], set_x[i+1], set_y[i+1]) == ORI_COL)
            i++;
         set_x[m] = set_x[i]; set_y[m] = set_y[i];
         m++;
      end
      if (n == 0 || m < 3) begin
         v = '{x: '0, y: '0, empty: 1'b1, last: 1'b1};
         if (keep) hull_q.push_back(v);
         return;
      end
      stk[0] = 0; stk[1] = 1; stk[2] = 2;
      depth = 3;
      for (int i = 3; i < m; i++) begin
         while (depth > 2 && turn(set_x[stk[depth-2]], set_y[stk[depth-2]],
                                  set_x[stk[depth-1]], set_y[stk[depth-1]],
                                  set_x[i], set_y[i]) != ORI_CCW)
            depth--;
         stk[depth] = i;
         depth++;
      end
      for (int k = 0; k < depth; k++) begin
         v.x = set_x[stk[k]][CB-1:0];
         v.y = set_y[stk[k]][CB-1:0];
         v.empty = 1'b0;
         v.last = (k + 1 == depth);
         if (keep) hull_q.push_back(v);
      end
   endfunction

   // Offer one point; called and returning at a falling edge
   task automatic send_point(int x, int y, bit last, bit typed);
      vertex_type v;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {x[CB-1:0], y[CB-1:0]} == 0 ? '0 : {y[CB-1:0], x[CB-1:0]};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (set_count < MAXP) begin
         set_x[set_count] = longint'($signed(x[CB-1:0]));
         set_y[set_count] = longint'($signed(y[CB-1:0]));
         set_count++;
      end
      if (last) begin
         predict_hull(!typed);
         if (typed) begin
            v = '{x: '0, y: '0, empty: 1'b1, last: 1'b1};
            hull_q.push_back(v);
         end
      end
      @(negedge clock);
   endtask

   // Receiver stalls
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle);

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      vertex_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hull_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected hull result x=%0d y=%0d empty=%0b last=%0b",
                        $signed(rsp_tdata[CB-1:0]), $signed(rsp_tdata[2*CB-1:CB]),
                        rsp_tuser, rsp_tlast);
         end else begin
            e = hull_q.pop_front();
            if (rsp_tdata[CB-1:0] !== e.x || rsp_tdata[2*CB-1:CB] !== e.y ||
                rsp_tuser !== e.empty || rsp_tlast !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"hull mismatch: exp x=%0d y=%0d empty=%0b last=%0b,",
                            " got x=%0d y=%0d empty=%0b last=%0b"},
                           $signed(e.x), $signed(e.y), e.empty, e.last,
                           $signed(rsp_tdata[CB-1:0]), $signed(rsp_tdata[2*CB-1:CB]),
                           rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // Directed sets: degenerate sets, extremes, pivot ties, pivot copies, collinear runs
   stim_row_type directed[] = '{
      '{5, 5, 1, 1},
      '{0, 0, 0, 0}, '{3, 4, 1, 1},
      '{0, 0, 0, 0}, '{1, 1, 0, 0}, '{2, 2, 1, 1},
      '{-32768, -32768, 0, 0}, '{32767, -32768, 0, 0},
      '{32767, 32767, 0, 0}, '{-32768, 32767, 1, 0},
      '{4, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{2, 0, 0, 0},
      '{0, 4, 0, 0}, '{0, 2, 0, 0}, '{1, 1, 0, 0}, '{4, 4, 1, 0},
      '{-1, -1, 0, 0}, '{-1, -1, 0, 0}, '{-1, -1, 1, 1},
      '{10, 3, 0, 0}, '{-7, 3, 0, 0}, '{0, -9, 0, 0}, '{32767, -32768, 1, 0}
   };

   initial begin
      int items;
      int n;
      int kind;
      int big_sets;
      int bx, by, dx, dy, span;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_point(directed[i].x, directed[i].y, directed[i].last, directed[i].typed);

      items = 0;
      big_sets = 0;
      while (items < 410) begin
         if (items >= 273) begin
            send_idle = 0; recv_idle = 0;
         end else if (items >= 137) begin
            send_idle = 76; recv_idle = 28;
         end
         kind = $urandom_range(99);
         if (kind >= 96 && big_sets < 3) begin
            // full store, sometimes overfull so points get dropped
            big_sets++;
            n = $urandom_range(MAXP + 4, MAXP - 1);
            for (int i = 0; i < n; i++) begin
               send_point($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                          i == n - 1, 0);
               items++;
            end
         end else if (kind < 55) begin
            // small cluster: duplicates and collinear points are common
            n = $urandom_range(12, 3);
            span = $urandom_range(6, 1);
            bx = $urandom_range(65535 - 2*span) - 32768 + span;
            by = $urandom_range(65535 - 2*span) - 32768 + span;
            for (int i = 0; i < n; i++) begin
               send_point(bx + $urandom_range(2*span) - span,
                          by + $urandom_range(2*span) - span, i == n - 1, 0);
               items++;
            end
         end else if (kind < 85) begin
            n = $urandom_range(16, 1);
            for (int i = 0; i < n; i++) begin
               send_point($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                          i == n - 1, 0);
               items++;
            end
         end else begin
            // points on one line, optionally one off it
            n = $urandom_range(8, 2);
            dx = $urandom_range(8) - 4;
            dy = $urandom_range(8) - 4;
            bx = $urandom_range(200) - 100;
            by = $urandom_range(200) - 100;
            for (int i = 0; i < n; i++) begin
               if (i == n - 1 && $urandom_range(1))
                  send_point(bx + 50, by - 70, 1, 0);
               else
                  send_point(bx + dx * $urandom_range(10), by + dy * $urandom_range(10),
                             i == n - 1, 0);
               items++;
            end
         end
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      while (hull_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && hull_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
design/gsh_pkg.sv
design/gsh_ram.sv
design/gsh_geom.sv
design/graham_scan_convex_hull_top.sv
test/graham_scan_convex_hull_top_tb.sv
